// File: src/qbm_pkg.sv
// Package: character codes, register indexes and shared types for the quality base masker.
`default_nettype none
package qbm_pkg;

    localparam int COORD_W  = 32;
    localparam int CHAR_W   = 8;
    localparam int CUTOFF_W = 9;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [CHAR_W-1:0] GAP_CH  = 8'd45;
    localparam logic [CHAR_W-1:0] N_CH    = 8'd78;
    localparam logic [CHAR_W-1:0] F_CH    = 8'd70;
    localparam logic [CHAR_W-1:0] ZERO_CH = 8'd48;

    localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_START = 1'b1;

    typedef struct packed {
        logic [COORD_W-1:0] coord;
        logic [COORD_W-1:0] open_start;
        logic               run_open;
    } t_run_state;

    typedef struct packed {
        logic [CHAR_W-1:0]  out_char;
        logic               run_valid;
        logic [COORD_W-1:0] run_start;
        logic [COORD_W-1:0] run_end;
        logic               end_at_gap;
    } t_result;

endpackage
`default_nettype wire

// File: src/qbm_ifs.sv
// Interfaces: column input stream, result output stream and register write channel.
`default_nettype none
interface qbm_in_if;
    import qbm_pkg::*;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] ref_char;
    logic [CHAR_W-1:0] seq_char;
    logic [CHAR_W-1:0] qual_char;
    logic              first_column;
    logic              last_column;
    modport source (output valid, ref_char, seq_char, qual_char, first_column, last_column,
                    input ready);
    modport sink   (input valid, ref_char, seq_char, qual_char, first_column, last_column,
                    output ready);
endinterface

interface qbm_out_if;
    import qbm_pkg::*;
    logic               valid;
    logic               ready;
    logic [CHAR_W-1:0]  out_char;
    logic               run_valid;
    logic [COORD_W-1:0] run_start;
    logic [COORD_W-1:0] run_end;
    logic               end_at_gap;
    modport source (output valid, out_char, run_valid, run_start, run_end, end_at_gap,
                    input ready);
    modport sink   (input valid, out_char, run_valid, run_start, run_end, end_at_gap,
                    output ready);
endinterface

interface qbm_cfg_if;
    import qbm_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: src/qbm_core.sv
// Column logic: masking decision, coordinate advance and run open/close/flush.
`default_nettype none
module qbm_core
    import qbm_pkg::*;
(
    input  wire logic [CUTOFF_W-1:0] i_cutoff,
    input  wire logic [COORD_W-1:0]  i_ref_start,
    input  wire t_run_state          i_state,
    input  wire logic [CHAR_W-1:0]   i_ref_char,
    input  wire logic [CHAR_W-1:0]   i_seq_char,
    input  wire logic [CHAR_W-1:0]   i_qual_char,
    input  wire logic                i_first_column,
    input  wire logic                i_last_column,
    output t_run_state               o_state,
    output t_result                  o_result
);

    logic               ref_gap;
    logic               qual_gap;
    logic               dbl_gap;
    logic signed [9:0]  qual_val;
    logic signed [9:0]  cutoff_ext;
    logic               masked;
    logic [COORD_W-1:0] col_coord;
    logic [COORD_W-1:0] next_coord;
    logic               open_in;
    logic               open_now;
    logic               close_now;
    logic               open_after;
    logic [COORD_W-1:0] start_after;
    logic               flush;

    always_comb begin
        ref_gap    = (i_ref_char == GAP_CH);
        qual_gap   = (i_qual_char == GAP_CH);
        dbl_gap    = ref_gap && qual_gap;
        qual_val   = $signed({2'b00, i_qual_char}) - $signed({2'b00, ZERO_CH});
        cutoff_ext = $signed({i_cutoff[CUTOFF_W-1], i_cutoff});
        masked     = !qual_gap && (i_qual_char != F_CH) && (qual_val <= cutoff_ext);

        col_coord  = i_first_column ? i_ref_start : i_state.coord;
        next_coord = ref_gap ? col_coord : col_coord + COORD_W'(1);
        open_in    = i_first_column ? 1'b0 : i_state.run_open;

        open_now   = !dbl_gap && masked && !open_in && !ref_gap;
        close_now  = !dbl_gap && !masked && open_in;
        open_after = open_now ? 1'b1 : (close_now ? 1'b0 : open_in);
        start_after = open_now ? col_coord : i_state.open_start;
        flush      = i_last_column && open_after;

        o_state.coord      = next_coord;
        o_state.open_start = start_after;
        o_state.run_open   = open_after && !flush;

        o_result.out_char   = (!dbl_gap && masked) ? N_CH : i_seq_char;
        o_result.run_valid  = close_now || flush;
        o_result.run_start  = (close_now || flush) ? start_after : '0;
        if (flush) begin
            o_result.run_end = next_coord;
        end else if (close_now && !ref_gap) begin
            o_result.run_end = col_coord;
        end else begin
            o_result.run_end = '0;
        end
        o_result.end_at_gap = close_now && ref_gap && !flush;
    end

endmodule
`default_nettype wire

// File: src/quality_base_masker_with_runs.sv
// Quality base masker with masked-run reporting: top level with registers and result stage.
// The result of an accepted column request is written into the output register on the following clock.
// Throughput: one column per cycle; the output register frees as it is read, so a new
// request is taken whenever the result slot is empty or being taken in the same cycle.
// Reset (synchronous, active low): cutoff, ref_start, coordinate, run state and result
// valid all cleared to zero.
`default_nettype none
module quality_base_masker_with_runs
    import qbm_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    qbm_in_if.sink     i_in,
    qbm_out_if.source  o_out,
    qbm_cfg_if.sink    i_cfg
);

    logic [CUTOFF_W-1:0] r_cutoff;
    logic [COORD_W-1:0]  r_ref_start;
    t_run_state          r_state;
    t_run_state          n_state;
    t_result             r_result;
    t_result             n_result;
    logic                r_out_valid;
    logic                in_fire;

    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign in_fire     = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    qbm_core u_core (
        .i_cutoff       (r_cutoff),
        .i_ref_start    (r_ref_start),
        .i_state        (r_state),
        .i_ref_char     (i_in.ref_char),
        .i_seq_char     (i_in.seq_char),
        .i_qual_char    (i_in.qual_char),
        .i_first_column (i_in.first_column),
        .i_last_column  (i_in.last_column),
        .o_state        (n_state),
        .o_result       (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cutoff    <= '0;
            r_ref_start <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_CUTOFF:    r_cutoff    <= i_cfg.data[CUTOFF_W-1:0];
                CFG_REF_START: r_ref_start <= i_cfg.data[COORD_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_result <= n_result;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.out_char   = r_result.out_char;
    assign o_out.run_valid  = r_result.run_valid;
    assign o_out.run_start  = r_result.run_start;
    assign o_out.run_end    = r_result.run_end;
    assign o_out.end_at_gap = r_result.end_at_gap;

endmodule
`default_nettype wire

// File: verif/tb_quality_base_masker_with_runs.sv
// Testbench for the quality base masker: directed rows, then random rows, mostly under random flow control.
module tb_quality_base_masker_with_runs;
    import qbm_pkg::*;

    class mask_run_board;
        int signed          cutoff;
        logic [COORD_W-1:0] ref_start;
        logic [COORD_W-1:0] coord;
        logic [COORD_W-1:0] open_start;
        bit                 run_open;
        t_result            col_results_due[$];
        int                 errors;
        int                 columns;
        int                 checked;
        int                 masked_bases;
        int                 runs;
        int                 gap_ends;

        function new();
            cutoff       = 0;
            ref_start    = '0;
            coord        = '0;
            open_start   = '0;
            run_open     = 1'b0;
            errors       = 0;
            columns      = 0;
            checked      = 0;
            masked_bases = 0;
            runs         = 0;
            gap_ends     = 0;
        endfunction

        function int pending();
            return col_results_due.size();
        endfunction

        task report(string what);
            errors++;
            $display("mismatch at result %0d: %s", checked, what);
        endtask

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            logic signed [CUTOFF_W-1:0] c9;
            if (idx == CFG_CUTOFF) begin
                c9     = data[CUTOFF_W-1:0];
                cutoff = c9;
            end else begin
                ref_start = data;
            end
        endfunction

        // Accepted column request: predict its result.
        function void note_column(logic [CHAR_W-1:0] rc, logic [CHAR_W-1:0] sc,
                                  logic [CHAR_W-1:0] qc, bit first, bit last);
            t_result            r;
            logic [COORD_W-1:0] col_coord;
            bit                 ref_gap;
            bit                 masked;
            r          = '0;
            r.out_char = sc;
            ref_gap    = (rc == GAP_CH);
            if (first) begin
                coord    = ref_start;
                run_open = 1'b0;
            end
            col_coord = coord;
            if (!ref_gap) begin
                coord = coord + 1;
            end
            if (!(qc == GAP_CH && ref_gap)) begin
                masked = (qc != GAP_CH) && (qc != F_CH) &&
                         (int'(qc) - int'(ZERO_CH) <= cutoff);
                if (masked) begin
                    r.out_char = N_CH;
                    masked_bases++;
                    if (!run_open && !ref_gap) begin
                        run_open   = 1'b1;
                        open_start = col_coord;
                    end
                end else if (run_open) begin
                    r.run_valid = 1'b1;
                    r.run_start = open_start;
                    if (ref_gap) begin
                        r.end_at_gap = 1'b1;
                    end else begin
                        r.run_end = col_coord;
                    end
                    run_open = 1'b0;
                end
            end
            if (last && run_open) begin
                r.run_valid  = 1'b1;
                r.run_start  = open_start;
                r.run_end    = coord;
                r.end_at_gap = 1'b0;
                run_open     = 1'b0;
            end
            runs     += int'(r.run_valid);
            gap_ends += int'(r.end_at_gap);
            columns++;
            col_results_due.push_back(r);
        endfunction

        task check_result(t_result got);
            t_result want;
            if (col_results_due.size() == 0) begin
                report($sformatf("result %p with no request outstanding", got));
                return;
            end
            want = col_results_due.pop_front();
            if (got.out_char !== want.out_char)
                report($sformatf("out_char got %h want %h", got.out_char, want.out_char));
            if (got.run_valid !== want.run_valid)
                report($sformatf("run_valid got %b want %b", got.run_valid, want.run_valid));
            if (got.run_start !== want.run_start)
                report($sformatf("run_start got %h want %h", got.run_start, want.run_start));
            if (got.run_end !== want.run_end)
                report($sformatf("run_end got %h want %h", got.run_end, want.run_end));
            if (got.end_at_gap !== want.end_at_gap)
                report($sformatf("end_at_gap got %b want %b", got.end_at_gap, want.end_at_gap));
            checked++;
        endtask

        task drop_outstanding();
            report($sformatf("%0d results never arrived", col_results_due.size()));
            col_results_due.delete();
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    qbm_in_if  in_ch();
    qbm_out_if out_ch();
    qbm_cfg_if cfg_ch();

    quality_base_masker_with_runs u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    mask_run_board board;

    bit rx_stalls = 1'b1;
    bit tx_gaps   = 1'b1;
    int rx_hold   = 0;
    int rx_burst  = 0;

    logic [CHAR_W-1:0] bases [4] = '{8'h41, 8'h43, 8'h47, 8'h54};

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // result side: long hold-off, random stall bursts, or always ready
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            out_ch.ready = 1'b0;
            rx_hold--;
        end else if (rx_burst > 0) begin
            out_ch.ready = 1'b0;
            rx_burst--;
        end else if (rx_stalls && $urandom_range(0, 4) == 0) begin
            out_ch.ready = 1'b0;
            rx_burst     = $urandom_range(0, 2);
        end else begin
            out_ch.ready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            board.check_result({out_ch.out_char, out_ch.run_valid, out_ch.run_start,
                                out_ch.run_end, out_ch.end_at_gap});
        end
    end

    initial begin
        #2_000_000;
        $display("tb_quality_base_masker_with_runs: FAIL");
        $finish;
    end

    task automatic send_column(input logic [CHAR_W-1:0] rc, input logic [CHAR_W-1:0] sc,
                               input logic [CHAR_W-1:0] qc, input bit first, input bit last);
        @(negedge i_clk);
        in_ch.valid        = 1'b1;
        in_ch.ref_char     = rc;
        in_ch.seq_char     = sc;
        in_ch.qual_char    = qc;
        in_ch.first_column = first;
        in_ch.last_column  = last;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        board.note_column(rc, sc, qc, first, last);
    endtask

    task automatic idle_input(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            in_ch.valid        = 1'b0;
            in_ch.ref_char     = 8'($urandom);
            in_ch.seq_char     = 8'($urandom);
            in_ch.qual_char    = 8'($urandom);
            in_ch.first_column = 1'($urandom);
            in_ch.last_column  = 1'($urandom);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = data;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        board.set_register(idx, data);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic drain();
        int waited;
        waited = 0;
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (board.pending() != 0 && waited < 400) begin
            @(posedge i_clk);
            waited++;
        end
        if (board.pending() != 0) begin
            board.drop_outstanding();
        end
        repeat (2) @(posedge i_clk);
    endtask

    task automatic send_row(input int len, input bit noisy);
        logic [CHAR_W-1:0] rc;
        logic [CHAR_W-1:0] sc;
        logic [CHAR_W-1:0] qc;
        bit                first;
        bit                last;
        for (int k = 0; k < len; k++) begin
            case ($urandom_range(0, 9))
                0, 1, 2: rc = GAP_CH;
                3:       rc = 8'($urandom);
                default: rc = bases[$urandom_range(0, 3)];
            endcase
            sc = ($urandom_range(0, 7) == 0) ? 8'($urandom) : bases[$urandom_range(0, 3)];
            case ($urandom_range(0, 9))
                0, 1:    qc = GAP_CH;
                2:       qc = F_CH;
                3:       qc = 8'($urandom);
                default: qc = ZERO_CH + 8'($urandom_range(0, 9));
            endcase
            first = (k == 0);
            last  = (k == len - 1);
            if (noisy) begin
                if ($urandom_range(0, 5) == 0) first = ~first;
                if ($urandom_range(0, 5) == 0) last = ~last;
            end
            send_column(rc, sc, qc, first, last);
            if (tx_gaps && $urandom_range(0, 5) == 0) begin
                idle_input($urandom_range(1, 3));
            end
        end
    endtask

    initial begin
        int                    cutoffs [8] = '{-64, 255, 4, -1, 9, 3, 0, 5};
        logic [CFG_DATA_W-1:0] starts  [8] = '{32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFF0, 32'd0,
                                               32'd1000, 32'd0, 32'h8000_0000, 32'd0};
        logic [CFG_DATA_W-1:0] cut_word;
        logic [CFG_DATA_W-1:0] start_word;
        int                    base_count;
        int                    len;
        bit                    held;
        bit                    paused;

        board              = new();
        i_rst_n            = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.ref_char     = '0;
        in_ch.seq_char     = '0;
        in_ch.qual_char    = '0;
        in_ch.first_column = 1'b0;
        in_ch.last_column  = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = CFG_CUTOFF;
        cfg_ch.data        = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings: cutoff 0, coordinates from 0
        send_column("A", "C", "0", 1'b1, 1'b0);
        send_column(GAP_CH, "G", GAP_CH, 1'b0, 1'b0);      // double gap
        send_column("G", "T", "5", 1'b0, 1'b0);            // closes run
        send_column("T", "A", "0", 1'b0, 1'b0);
        send_column(GAP_CH, "C", F_CH, 1'b0, 1'b0);        // closes on reference gap
        send_column(GAP_CH, "A", "0", 1'b0, 1'b0);         // masked on gap, no run opened
        send_column("C", "G", "0", 1'b0, 1'b0);
        send_column(GAP_CH, "T", "0", 1'b0, 1'b1);         // flushed at row end
        send_column("A", "G", "0", 1'b1, 1'b1);            // first and last together
        send_column(8'h00, 8'hFF, 8'h00, 1'b1, 1'b0);
        send_column(8'hFF, 8'h00, 8'hFF, 1'b0, 1'b0);
        send_column("A", "A", "9", 1'b0, 1'b0);
        send_column("A", "C", "0", 1'b0, 1'b0);
        send_column("G", "T", "0", 1'b0, 1'b1);
        send_column("G", "T", "0", 1'b0, 1'b0);            // no first column: coordinate carried on
        send_column(GAP_CH, "A", F_CH, 1'b0, 1'b1);
        send_column(GAP_CH, "C", GAP_CH, 1'b1, 1'b1);
        send_column("A", "C", "/", 1'b1, 1'b0);
        send_column("A", "C", "1", 1'b0, 1'b1);

        for (int ph = 0; ph < 8; ph++) begin
            drain();
            cut_word = 32'(cutoffs[ph]) & 32'h1FF;
            if (ph % 2 == 1) cut_word |= $urandom & ~32'h1FF;
            start_word = (starts[ph] == 0 && ph != 1) ? 32'($urandom) : starts[ph];
            write_reg(CFG_CUTOFF, cut_word);
            write_reg(CFG_REF_START, start_word);
            if (ph == 7) begin
                rx_stalls = 1'b0;
                tx_gaps   = 1'b0;
            end
            base_count = board.columns;
            held       = 1'b0;
            paused     = 1'b0;
            while (board.columns - base_count < 155) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
                send_row(len, $urandom_range(0, 9) == 0);
                if (ph == 2 && !held && board.columns - base_count > 40) begin
                    rx_hold = 60;
                    held    = 1'b1;
                end
                if (ph == 4 && !paused && board.columns - base_count > 60) begin
                    drain();
                    paused = 1'b1;
                end
            end
        end

        drain();
        repeat (4) @(posedge i_clk);
        $display("Covered %0d columns: %0d masked bases, %0d runs reported, %0d closed on a gap.",
                 board.columns, board.masked_bases, board.runs, board.gap_ends);
        $display("Eight register settings incl. cutoff -64 and 255 and coordinate wrap; %0d errors.",
                 board.errors);
        if (board.errors == 0) begin
            $display("tb_quality_base_masker_with_runs: PASS");
        end else begin
            $display("tb_quality_base_masker_with_runs: FAIL");
        end
        $finish;
    end

endmodule
